### rtl/lmm_pkg.sv
// shared types, codes and constants of the led mode sequencer
`default_nettype none

package lmm_pkg;

    localparam int PATTERN_DEPTH_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ON  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RED      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE     = 3'd6;

    // mode codes
    localparam logic [1:0] MODE_LIGHT = 2'd0;
    localparam logic [1:0] MODE_BLINK = 2'd1;
    localparam logic [1:0] MODE_MORSE = 2'd2;

    // item kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // symbol codes, anything above is unknown
    localparam logic [2:0] SYM_DOT    = 3'd0;
    localparam logic [2:0] SYM_DASH   = 3'd1;
    localparam logic [2:0] SYM_LETTER = 3'd2;
    localparam logic [2:0] SYM_WORD   = 3'd3;

    // reset values of the registers
    localparam logic [15:0] BLINK_MS_RST = 16'd500;
    localparam logic [9:0]  DOT_MS_RST   = 10'd100;
    localparam logic [7:0]  COLOR_RST    = 8'd25;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic       led_on;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       busy_res;
        logic       finished;
        logic       bad_symbol;
    } t_out_item;

    function automatic logic is_mark(input logic [2:0] sym);
        return (sym == SYM_DOT) || (sym == SYM_DASH);
    endfunction

endpackage

`default_nettype wire

### rtl/lmm_ram.sv
// generic single write, single read ram with registered read and write forwarding
`default_nettype none

module lmm_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/led_mode_morse_blink_sequencer.sv
// led mode sequencer: steady light, blink and morse playback driven by tick items
//
// usage: items arrive on the input channel (i_in_valid / o_in_ready, payload
// i_in_data) as ticks of one millisecond, symbol appends, mode starts or
// pattern clears. every transfer produces exactly one result on the output
// channel (o_out_valid / i_out_ready, payload o_out_data) with the led level,
// the colour driven, the busy flag and the finished / bad symbol flags.
// the result is in the output register on the cycle after the input transfer.
// throughput is one item per cycle; the state update and the pattern ram read
// for the next step both complete in that cycle. the pattern ram is read one
// item ahead at the next play index, so a step always sees its own symbol and
// the mark flag of its successor without a wait. configuration is written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while
// the block is idle, which the block does not enforce. reset restores the
// register defaults, empties the pattern and stops both sequences; no clearing
// pass is needed. when the receiver stalls the result stays in the output
// register and o_in_ready drops until it is taken; a new item is taken in the
// same cycle as the waiting result is transferred.
`default_nettype none

module led_mode_morse_blink_sequencer #(
    parameter int PATTERN_DEPTH = lmm_pkg::PATTERN_DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire lmm_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output lmm_pkg::t_out_item                    o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [lmm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [lmm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import lmm_pkg::*;

    localparam int PW = $clog2(PATTERN_DEPTH + 1);
    localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;

    // configuration
    logic [1:0]  r_mode;
    logic        r_base_on;
    logic [15:0] r_blink_ms;
    logic [9:0]  r_dot_ms;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    // sequencer state
    logic          r_lit;
    logic [PW-1:0] r_pat_len;
    logic [PW-1:0] r_play_idx;
    logic          r_gap;
    logic          r_morse_run;
    logic [12:0]   r_rem_ms;
    logic [15:0]   r_blink_cnt;
    logic          r_blink_run;

    logic          r_out_valid;
    t_out_item     r_out_data;

    logic          n_lit;
    logic [PW-1:0] n_pat_len;
    logic [PW-1:0] n_play_idx;
    logic          n_gap;
    logic          n_morse_run;
    logic [12:0]   n_rem_ms;
    logic [15:0]   n_blink_cnt;
    logic          n_blink_run;
    t_out_item     n_out_data;

    logic          accept;
    logic          do_step;
    logic          fin;
    logic          bad;
    logic          gap_eff;
    logic          sym_we;
    logic          mark_we;
    logic [2:0]    cur_sym;
    logic          next_mark;
    logic [PW-1:0] pat_len_m1;
    logic [PW:0]   idx_inc;
    logic [15:0]   blink_per;
    logic [16:0]   cnt_inc;
    logic [12:0]   unit_1;
    logic [12:0]   unit_3;
    logic [12:0]   unit_7;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign pat_len_m1 = r_pat_len - PW'(1);
    assign idx_inc    = {1'b0, r_play_idx} + (PW+1)'(1);
    assign blink_per  = (r_blink_ms == '0) ? 16'd1 : r_blink_ms;
    assign cnt_inc    = {1'b0, r_blink_cnt} + 17'd1;
    assign unit_1     = {3'b000, ((r_dot_ms == '0) ? 10'd1 : r_dot_ms)};
    assign unit_3     = (unit_1 << 1) + unit_1;
    assign unit_7     = (unit_1 << 3) - unit_1;

    // symbol at each index, and whether the symbol after it is a dot or dash
    lmm_ram #(
        .WIDTH (3),
        .DEPTH (PATTERN_DEPTH)
    ) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (r_pat_len[AW-1:0]),
        .i_wdata (i_in_data.symbol),
        .i_raddr (n_play_idx[AW-1:0]),
        .o_rdata (cur_sym)
    );

    lmm_ram #(
        .WIDTH (1),
        .DEPTH (PATTERN_DEPTH)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (pat_len_m1[AW-1:0]),
        .i_wdata (is_mark(i_in_data.symbol)),
        .i_raddr (n_play_idx[AW-1:0]),
        .o_rdata (next_mark)
    );

    always_comb begin
        n_lit       = r_lit;
        n_pat_len   = r_pat_len;
        n_play_idx  = r_play_idx;
        n_gap       = r_gap;
        n_morse_run = r_morse_run;
        n_rem_ms    = r_rem_ms;
        n_blink_cnt = r_blink_cnt;
        n_blink_run = r_blink_run;
        do_step     = 1'b0;
        fin         = 1'b0;
        bad         = 1'b0;
        sym_we      = 1'b0;
        mark_we     = 1'b0;
        gap_eff     = (r_play_idx == '0) ? 1'b0 : r_gap;

        if (accept) begin
            unique case (i_in_data.kind)
                KIND_TICK: begin
                    if (r_blink_run) begin
                        if (cnt_inc >= {1'b0, blink_per}) begin
                            n_lit       = ~r_lit;
                            n_blink_cnt = '0;
                        end else begin
                            n_blink_cnt = cnt_inc[15:0];
                        end
                    end
                    if (r_morse_run) begin
                        if (r_rem_ms > 13'd1) begin
                            n_rem_ms = r_rem_ms - 13'd1;
                        end else begin
                            n_rem_ms = '0;
                            do_step  = 1'b1;
                        end
                    end
                end
                KIND_APPEND: begin
                    if (r_pat_len < PW'(PATTERN_DEPTH)) begin
                        sym_we    = 1'b1;
                        mark_we   = (r_pat_len != '0);
                        n_pat_len = r_pat_len + PW'(1);
                    end
                end
                KIND_START: begin
                    n_blink_run = 1'b0;
                    n_morse_run = 1'b0;
                    unique case (r_mode)
                        MODE_LIGHT: n_lit = r_base_on;
                        MODE_BLINK: begin
                            n_blink_run = 1'b1;
                            n_blink_cnt = '0;
                        end
                        MODE_MORSE: begin
                            n_morse_run = 1'b1;
                            n_rem_ms    = '0;
                            do_step     = 1'b1;
                        end
                        default: ;
                    endcase
                end
                KIND_CLEAR: n_pat_len = '0;
                default: ;
            endcase
        end

        // one morse step
        if (do_step) begin
            n_gap = gap_eff;
            if (r_play_idx >= r_pat_len) begin
                n_lit       = 1'b0;
                n_play_idx  = '0;
                n_morse_run = 1'b0;
                fin         = 1'b1;
            end else if (gap_eff) begin
                n_lit    = 1'b0;
                n_rem_ms = unit_1;
                n_gap    = 1'b0;
            end else begin
                unique case (cur_sym)
                    SYM_DOT: begin
                        n_lit    = 1'b1;
                        n_rem_ms = unit_1;
                    end
                    SYM_DASH: begin
                        n_lit    = 1'b1;
                        n_rem_ms = unit_3;
                    end
                    SYM_LETTER: begin
                        n_lit    = 1'b0;
                        n_rem_ms = unit_3;
                    end
                    SYM_WORD: begin
                        n_lit    = 1'b0;
                        n_rem_ms = unit_7;
                    end
                    default: begin
                        n_morse_run = 1'b0;
                        bad         = 1'b1;
                    end
                endcase
                n_play_idx = idx_inc[PW-1:0];
                n_gap      = (idx_inc < {1'b0, r_pat_len}) && is_mark(cur_sym) && next_mark;
            end
        end

        n_out_data.led_on     = n_lit;
        n_out_data.out_red    = n_lit ? r_red : 8'd0;
        n_out_data.out_green  = n_lit ? r_green : 8'd0;
        n_out_data.out_blue   = n_lit ? r_blue : 8'd0;
        n_out_data.busy_res   = n_blink_run || n_morse_run;
        n_out_data.finished   = fin;
        n_out_data.bad_symbol = bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LIGHT;
            r_base_on   <= 1'b0;
            r_blink_ms  <= BLINK_MS_RST;
            r_dot_ms    <= DOT_MS_RST;
            r_red       <= COLOR_RST;
            r_green     <= COLOR_RST;
            r_blue      <= COLOR_RST;
            r_lit       <= 1'b0;
            r_pat_len   <= '0;
            r_play_idx  <= '0;
            r_gap       <= 1'b0;
            r_morse_run <= 1'b0;
            r_rem_ms    <= '0;
            r_blink_cnt <= '0;
            r_blink_run <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODE:     r_mode     <= i_cfg_data[1:0];
                    REG_BASE_ON:  r_base_on  <= i_cfg_data[0];
                    REG_BLINK_MS: r_blink_ms <= i_cfg_data[15:0];
                    REG_DOT_MS:   r_dot_ms   <= i_cfg_data[9:0];
                    REG_RED:      r_red      <= i_cfg_data[7:0];
                    REG_GREEN:    r_green    <= i_cfg_data[7:0];
                    REG_BLUE:     r_blue     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_lit       <= n_lit;
            r_pat_len   <= n_pat_len;
            r_play_idx  <= n_play_idx;
            r_gap       <= n_gap;
            r_morse_run <= n_morse_run;
            r_rem_ms    <= n_rem_ms;
            r_blink_cnt <= n_blink_cnt;
            r_blink_run <= n_blink_run;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_one_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_blink_run && r_morse_run))
        else $error("blink and morse running together");

    a_morse_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_morse_run |-> (r_rem_ms != '0))
        else $error("morse running with an expired unit timer");

    a_end_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.finished && o_out_data.bad_symbol))
        else $error("finished and bad symbol on one result");

    a_finish_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.finished) |-> (!o_out_data.led_on && !o_out_data.busy_res))
        else $error("finished result with led lit or sequence busy");
`endif

endmodule

`default_nettype wire
